@@ hw/rtl/rpfm_pkg.sv @@
// shared codes for the rayleigh phase matrix fourier moment block
package rpfm_pkg;

  localparam logic MODE_ORDER1 = 1'b0;
  localparam logic MODE_ORDER2 = 1'b1;

endpackage

@@ hw/rtl/rayleigh_phase_fourier_moment.sv @@
// rayleigh phase matrix first column, fourier orders one and two, fixed point pipeline
//
// One (sun cosine, node cosine) pair enters on every cycle that the output side is
// not stalled and the scale divider is not busy, and the three first-column elements
// leave in signed Q1.FRAC_BITS, saturated to +-1.
// The square root resolves one root bit per stage over FRAC_BITS+1 stages; the
// multipliers sit in stages of their own around it.
// The scale (1-d)/(1+d/2) is produced by a radix-2 divider after every write to
// the depolarization register: the write channel and the input channel both hold
// ready low while it runs. After reset the scale is one.
module rayleigh_phase_fourier_moment
  import rpfm_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [FRAC_BITS-1:0]                     cfg_data,      // depolarization
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  logic [((2*FRAC_BITS+10)/8)*8-1:0]        s_axis_tdata,  // sun_cosine, node_cosine
  input  logic                                     s_axis_tuser,  // mode
  input  logic                                     s_axis_tlast,  // last_pair
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  output logic [((3*FRAC_BITS+13)/8)*8-1:0]        m_axis_tdata,  // elem_one, elem_two, elem_three
  output logic                                     m_axis_tlast   // last
);

  localparam int F      = FRAC_BITS;
  localparam int W1     = F + 1;
  localparam int W2     = F + 2;
  localparam int WP     = 2 * F + 2;
  localparam int OUT_DW = ((3 * F + 13) / 8) * 8;
  localparam int CW     = $clog2(F + 1);

  localparam logic [W1-1:0]        ONE       = {1'b1, {F{1'b0}}};
  localparam logic signed [W2-1:0] ONE_S     = {2'b01, {F{1'b0}}};
  localparam logic signed [W2-1:0] NEG_ONE_S = {2'b11, {F{1'b0}}};
  localparam logic [WP-1:0]        ONE_SQ    = {2'b01, {(2 * F){1'b0}}};
  localparam logic [WP:0]          HALF      = {{(F + 3){1'b0}}, 1'b1, {(F - 1){1'b0}}};

  typedef struct packed {
    logic [W1-1:0]        c;
    logic signed [W2-1:0] mu;
    logic                 mode;
    logic                 last;
    logic [W1-1:0]        e1;
    logic [W1-1:0]        e2;
    logic [W1-1:0]        e3;
  } side_t;

  function automatic logic [W1-1:0] rnd_q(input logic [WP:0] v);
    logic [WP:0] t;
    t = v + HALF;
    return t[F+W1-1:F];
  endfunction

  function automatic logic [W1-1:0] mag_q(input logic signed [W2-1:0] v);
    logic signed [W2-1:0] n;
    n = -v;
    return v[W2-1] ? n[W1-1:0] : v[W1-1:0];
  endfunction

  function automatic logic signed [W2-1:0] sgn_q(input logic [W1-1:0] m, input logic neg);
    logic signed [W2-1:0] t;
    t = $signed({1'b0, m});
    return neg ? -t : t;
  endfunction

  function automatic logic signed [W2-1:0] sat_q(input logic signed [W2-1:0] v);
    if (v > ONE_S) begin
      return ONE_S;
    end else if (v < NEG_ONE_S) begin
      return NEG_ONE_S;
    end
    return v;
  endfunction

  // scale divider
  logic [W1-1:0] df;
  logic          div_busy;
  logic [CW-1:0] div_cnt;
  logic [W2-1:0] div_den;
  logic [W2-1:0] div_rem;
  logic [W1-1:0] div_nq;
  logic          cfg_acc;
  logic [W1-1:0] one_minus;
  logic [W2-1:0] den_new;
  logic [WP-1:0] num_new;
  logic [W2:0]   div_r2;
  logic          div_ge;
  logic [W2-1:0] rem_next;
  logic [W1-1:0] nq_next;

  assign cfg_ready = !div_busy;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign one_minus = ONE - {1'b0, cfg_data};
  assign den_new   = {ONE, 1'b0} + W2'(cfg_data);
  assign num_new   = (WP'({one_minus, 1'b0}) << F) + WP'(den_new >> 1);
  assign div_r2    = {div_rem, div_nq[F]};
  assign div_ge    = div_r2 >= {1'b0, div_den};
  assign rem_next  = div_ge ? W2'(div_r2 - {1'b0, div_den}) : div_r2[W2-1:0];
  assign nq_next   = {div_nq[F-1:0], div_ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      df       <= ONE;
      div_busy <= 1'b0;
      div_cnt  <= '0;
    end else if (cfg_acc) begin
      div_busy <= 1'b1;
      div_cnt  <= CW'(F);
    end else if (div_busy) begin
      div_cnt <= div_cnt - CW'(1);
      if (div_cnt == '0) begin
        div_busy <= 1'b0;
        df       <= nq_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_acc) begin
      div_den <= den_new;
      div_rem <= W2'(num_new[WP-1:F+1]);
      div_nq  <= num_new[F:0];
    end else if (div_busy) begin
      div_rem <= rem_next;
      div_nq  <= nq_next;
    end
  end

  // pipeline flow
  logic adv;
  logic o_vld;
  logic in_acc;

  assign adv           = !o_vld || m_axis_tready;
  assign s_axis_tready = adv && !div_busy;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // input clamp
  logic [W1-1:0]        in_sun;
  logic signed [W2-1:0] in_node;
  logic signed [W2-1:0] node_c;
  logic [W1-1:0]        node_m;
  logic [W1-1:0]        sun_c;

  assign in_sun  = s_axis_tdata[F:0];
  assign in_node = $signed(s_axis_tdata[2*F+2:F+1]);
  assign node_c  = (in_node > ONE_S) ? ONE_S : ((in_node < NEG_ONE_S) ? NEG_ONE_S : in_node);
  assign node_m  = mag_q(node_c);
  assign sun_c   = (in_sun > ONE) ? ONE : in_sun;

  logic                 v1, v2, v3, v4, v5, v6, v7;
  logic                 s1_mode, s2_mode, s3_mode, s4_mode;
  logic                 s1_last, s2_last, s3_last, s4_last;
  logic signed [W2-1:0] s1_mu, s2_mu, s3_mu, s4_mu;
  logic [W1-1:0]        s1_mu0;
  logic [WP-1:0]        s1_sqmu, s1_sqmu0;
  logic [W1-1:0]        s2_mu2, s2_b, s2_a, s2_bw;
  logic [WP-1:0]        s2_pm0;
  logic [WP-1:0]        s3_x, s3_pbp;
  logic [W1-1:0]        s3_c, s3_mu2;
  logic [WP-1:0]        s4_x;
  logic [W1-1:0]        s4_c, s4_mu2, s4_q;
  logic [WP-1:0]        s5_x;
  side_t                s5_side;
  logic [WP-1:0]        s6_zp;
  side_t                s6_side;
  logic [W1-1:0]        s7_z;
  logic [WP-1:0]        s7_ep;
  side_t                s7_side;
  logic signed [W2-1:0] o_e1, o_e2, o_e3;
  logic                 o_last;

  logic [W1+1:0] c_sum;
  logic [W1+1:0] q_sum;
  logic [W2-1:0] one_plus;
  logic [W1-1:0] s4_mum;

  assign c_sum    = (W1 + 2)'(rnd_q((WP + 1)'(s2_pm0))) * (W1 + 2)'(3) + (W1 + 2)'(2);
  assign q_sum    = (W1 + 2)'(rnd_q((WP + 1)'(s3_pbp))) * (W1 + 2)'(3) + (W1 + 2)'(8);
  assign one_plus = W2'(ONE) + W2'(s4_mu2);
  assign s4_mum   = mag_q(s4_mu);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mode  <= s_axis_tuser;
      s1_last  <= s_axis_tlast;
      s1_mu    <= node_c;
      s1_mu0   <= sun_c;
      s1_sqmu  <= WP'(node_m) * WP'(node_m);
      s1_sqmu0 <= WP'(sun_c) * WP'(sun_c);

      s2_mode <= s1_mode;
      s2_last <= s1_last;
      s2_mu   <= s1_mu;
      s2_mu2  <= rnd_q((WP + 1)'(s1_sqmu));
      s2_b    <= ONE - rnd_q((WP + 1)'(s1_sqmu0));
      s2_a    <= rnd_q((WP + 1)'(ONE_SQ - s1_sqmu));
      s2_bw   <= rnd_q((WP + 1)'(ONE_SQ - s1_sqmu0));
      s2_pm0  <= WP'(df) * WP'(s1_mu0);

      s3_mode <= s2_mode;
      s3_last <= s2_last;
      s3_mu   <= s2_mu;
      s3_mu2  <= s2_mu2;
      s3_x    <= WP'(s2_a) * WP'(s2_bw);
      s3_pbp  <= WP'(df) * WP'(s2_b);
      s3_c    <= c_sum[W1+1:2];

      s4_mode <= s3_mode;
      s4_last <= s3_last;
      s4_mu   <= s3_mu;
      s4_mu2  <= s3_mu2;
      s4_x    <= s3_x;
      s4_c    <= s3_c;
      s4_q    <= W1'(q_sum[W1+1:4]);

      s5_x         <= s4_x;
      s5_side.c    <= s4_c;
      s5_side.mu   <= s4_mu;
      s5_side.mode <= s4_mode;
      s5_side.last <= s4_last;
      s5_side.e1   <= rnd_q((WP + 1)'(s4_q) * (WP + 1)'(ONE - s4_mu2));
      s5_side.e2   <= rnd_q((WP + 1)'(s4_q) * (WP + 1)'(one_plus));
      s5_side.e3   <= rnd_q((WP + 1)'({s4_q, 1'b0}) * (WP + 1)'(s4_mum));
    end
  end

  // square root, one root bit per stage
  logic [WP-1:0] sq_rem  [1:F+1];
  logic [W1-1:0] sq_root [1:F+1];
  side_t         sq_side [1:F+1];
  logic          sq_vld  [1:F+1];

  for (genvar k = 0; k <= F; k++) begin : g_sqrt
    localparam int BIT = F - k;
    logic [WP-1:0] rem_in;
    logic [W1-1:0] root_in;
    side_t         side_in;
    logic          vld_in;
    logic [WP:0]   trial;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in  = s5_x;
      assign root_in = '0;
      assign side_in = s5_side;
      assign vld_in  = v5;
    end else begin : g_next
      assign rem_in  = sq_rem[k];
      assign root_in = sq_root[k];
      assign side_in = sq_side[k];
      assign vld_in  = sq_vld[k];
    end

    assign trial = ((WP + 1)'(root_in) << (BIT + 1)) + ((WP + 1)'(1) << (2 * BIT));
    assign take  = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem[k+1]  <= take ? WP'({1'b0, rem_in} - trial) : rem_in;
        sq_root[k+1] <= take ? (root_in | (W1'(1) << BIT)) : root_in;
        sq_side[k+1] <= side_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[k+1] <= 1'b0;
      end else if (adv) begin
        sq_vld[k+1] <= vld_in;
      end
    end
  end

  // order one tail and output select
  logic [W1-1:0]        z_new;
  logic [W1-1:0]        m0_mag;
  logic                 out_neg;
  logic signed [W2-1:0] m0_e1;
  logic signed [W2-1:0] e1_next, e2_next, e3_next;

  assign z_new   = rnd_q((WP + 1)'(s6_zp));
  assign m0_mag  = rnd_q((WP + 1)'(s7_ep));
  assign out_neg = s7_side.mu[W2-1];
  assign m0_e1   = sgn_q(m0_mag, out_neg);

  always_comb begin
    if (s7_side.mode == MODE_ORDER2) begin
      e1_next = sgn_q(s7_side.e1, 1'b0);
      e2_next = sgn_q(s7_side.e2, 1'b1);
      e3_next = sgn_q(s7_side.e3, out_neg);
    end else begin
      e1_next = m0_e1;
      e2_next = m0_e1;
      e3_next = sgn_q(s7_z, 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_zp   <= WP'(sq_side[F+1].c) * WP'(sq_root[F+1]);
      s6_side <= sq_side[F+1];

      s7_z    <= z_new;
      s7_ep   <= WP'(z_new) * WP'(mag_q(s6_side.mu));
      s7_side <= s6_side;

      o_e1   <= sat_q(e1_next);
      o_e2   <= sat_q(e2_next);
      o_e3   <= sat_q(e3_next);
      o_last <= s7_side.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      v4    <= 1'b0;
      v5    <= 1'b0;
      v6    <= 1'b0;
      v7    <= 1'b0;
      o_vld <= 1'b0;
    end else if (adv) begin
      v1    <= in_acc;
      v2    <= v1;
      v3    <= v2;
      v4    <= v3;
      v5    <= v4;
      v6    <= sq_vld[F+1];
      v7    <= v6;
      o_vld <= v7;
    end
  end

  assign m_axis_tvalid = o_vld;
  assign m_axis_tdata  = OUT_DW'({o_e3, o_e2, o_e1});
  assign m_axis_tlast  = o_last;

endmodule
